FILE: hw/rtl/sm83x_pkg.sv
`timescale 1ns / 1ps

package sm83x_pkg;

    localparam logic [15:0] SP_RESET = 16'hFFFE;

    localparam int FLG_Z = 3;
    localparam int FLG_N = 2;
    localparam int FLG_H = 1;
    localparam int FLG_C = 0;

    localparam logic [7:0] OP_BLOCK_LO = 8'hC0;
    localparam logic [7:0] OP_BLOCK_HI = 8'hDF;
    localparam logic [7:0] OP_POP_BC   = 8'hC1;
    localparam logic [7:0] OP_POP_DE   = 8'hD1;
    localparam logic [7:0] OP_JP       = 8'hC3;
    localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
    localparam logic [7:0] OP_PUSH_DE  = 8'hD5;
    localparam logic [7:0] OP_CALL     = 8'hCD;

    typedef enum logic [2:0] {
        GRP_RET_CC  = 3'd0,
        GRP_POP_RET = 3'd1,
        GRP_JP_CC   = 3'd2,
        GRP_JP      = 3'd3,
        GRP_CALL_CC = 3'd4,
        GRP_PUSH    = 3'd5,
        GRP_ALU     = 3'd6,
        GRP_RST     = 3'd7
    } grp_t;

    typedef enum logic [1:0] {
        CC_NZ = 2'd0,
        CC_Z  = 2'd1,
        CC_NC = 2'd2,
        CC_C  = 2'd3
    } cc_t;

    typedef struct packed {
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] sp;
        logic [15:0] pc;
    } arch_t;

    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [15:0] data;
    } wr_t;

    typedef struct packed {
        wr_t   wr;
        arch_t st;
    } res_t;

endpackage

FILE: hw/rtl/sm83x_req_if.sv
`timescale 1ns / 1ps

interface sm83x_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cmd;
    logic [15:0] imm_word;
    logic [15:0] stack_word;

    modport source (output valid, output cmd, output imm_word, output stack_word, input ready);
    modport sink (input valid, input cmd, input imm_word, input stack_word, output ready);
endinterface

FILE: hw/rtl/sm83x_rsp_if.sv
`timescale 1ns / 1ps

interface sm83x_rsp_if;
    logic        valid;
    logic        ready;
    logic        write_enable;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic [15:0] next_pc;
    logic [15:0] next_sp;
    logic [7:0]  acc_out;
    logic [3:0]  flags_out;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;

    modport source (
        output valid, output write_enable, output write_addr, output write_data,
        output next_pc, output next_sp, output acc_out, output flags_out,
        output pair_bc, output pair_de, input ready
    );
    modport sink (
        input valid, input write_enable, input write_addr, input write_data,
        input next_pc, input next_sp, input acc_out, input flags_out,
        input pair_bc, input pair_de, output ready
    );
endinterface

FILE: hw/rtl/sm83x_exec.sv
`timescale 1ns / 1ps

module sm83x_exec (
    input  logic [7:0]       cmd,
    input  logic [15:0]      imm_word,
    input  logic [15:0]      stack_word,
    input  sm83x_pkg::arch_t cur,
    output sm83x_pkg::arch_t nxt,
    output sm83x_pkg::wr_t   wr
);
    import sm83x_pkg::*;

    logic        cond;
    logic        cin;
    logic [7:0]  n;
    logic [8:0]  add_sum;
    logic [4:0]  add_half;
    logic [7:0]  sub_res;
    logic        sub_h;
    logic        sub_c;
    logic [7:0]  alu_res;
    logic        alu_h;
    logic        alu_c;
    logic        is_sub;
    logic [15:0] pc_p1;
    logic [15:0] pc_p2;
    logic [15:0] pc_p3;
    logic [15:0] sp_up;
    logic [15:0] sp_dn;

    assign n      = imm_word[7:0];
    assign cin    = cmd[3] & cur.flags[FLG_C];
    assign is_sub = cmd[4];
    assign pc_p1  = cur.pc + 16'd1;
    assign pc_p2  = cur.pc + 16'd2;
    assign pc_p3  = cur.pc + 16'd3;
    assign sp_up  = cur.sp + 16'd2;
    assign sp_dn  = cur.sp - 16'd2;

    always_comb
    begin
        case (cc_t'(cmd[4:3]))
            CC_NZ:   cond = !cur.flags[FLG_Z];
            CC_Z:    cond = cur.flags[FLG_Z];
            CC_NC:   cond = !cur.flags[FLG_C];
            CC_C:    cond = cur.flags[FLG_C];
            default: cond = 1'b0;
        endcase
    end

    assign add_sum  = {1'b0, cur.acc} + {1'b0, n} + {8'd0, cin};
    assign add_half = {1'b0, cur.acc[3:0]} + {1'b0, n[3:0]} + {4'd0, cin};
    assign sub_res  = cur.acc - n - {7'd0, cin};
    assign sub_h    = ({1'b0, n[3:0]} + {4'd0, cin}) > {1'b0, cur.acc[3:0]};
    assign sub_c    = ({1'b0, n} + {8'd0, cin}) > {1'b0, cur.acc};

    assign alu_res = is_sub ? sub_res : add_sum[7:0];
    assign alu_h   = is_sub ? sub_h : add_half[4];
    assign alu_c   = is_sub ? sub_c : add_sum[8];

    always_comb
    begin
        nxt = cur;
        wr  = '0;
        if (cmd inside {[OP_BLOCK_LO:OP_BLOCK_HI]})
        begin
            case (grp_t'(cmd[2:0]))
                GRP_RET_CC:
                begin
                    if (cond)
                    begin
                        nxt.pc = stack_word;
                        nxt.sp = sp_up;
                    end
                    else
                    begin
                        nxt.pc = pc_p1;
                    end
                end
                GRP_POP_RET:
                begin
                    nxt.sp = sp_up;
                    if (cmd == OP_POP_BC)
                    begin
                        nxt.bc = stack_word;
                        nxt.pc = pc_p1;
                    end
                    else if (cmd == OP_POP_DE)
                    begin
                        nxt.de = stack_word;
                        nxt.pc = pc_p1;
                    end
                    else
                    begin
                        nxt.pc = stack_word;
                    end
                end
                GRP_JP_CC:
                begin
                    nxt.pc = cond ? imm_word : pc_p3;
                end
                GRP_JP:
                begin
                    if (cmd == OP_JP)
                    begin
                        nxt.pc = imm_word;
                    end
                end
                GRP_CALL_CC:
                begin
                    if (cond)
                    begin
                        nxt.sp = sp_dn;
                        nxt.pc = imm_word;
                        wr     = '{en: 1'b1, addr: sp_dn, data: pc_p3};
                    end
                    else
                    begin
                        nxt.pc = pc_p3;
                    end
                end
                GRP_PUSH:
                begin
                    if (cmd == OP_PUSH_BC)
                    begin
                        nxt.sp = sp_dn;
                        nxt.pc = pc_p1;
                        wr     = '{en: 1'b1, addr: sp_dn, data: cur.bc};
                    end
                    else if (cmd == OP_PUSH_DE)
                    begin
                        nxt.sp = sp_dn;
                        nxt.pc = pc_p1;
                        wr     = '{en: 1'b1, addr: sp_dn, data: cur.de};
                    end
                    else if (cmd == OP_CALL)
                    begin
                        nxt.sp = sp_dn;
                        nxt.pc = imm_word;
                        wr     = '{en: 1'b1, addr: sp_dn, data: pc_p3};
                    end
                end
                GRP_ALU:
                begin
                    nxt.acc   = alu_res;
                    nxt.flags = {alu_res == 8'd0, is_sub, alu_h, alu_c};
                    nxt.pc    = pc_p2;
                end
                GRP_RST:
                begin
                    nxt.sp = sp_dn;
                    nxt.pc = {10'd0, cmd[5:3], 3'd0};
                    wr     = '{en: 1'b1, addr: sp_dn, data: pc_p1};
                end
                default:
                begin
                    nxt = cur;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/sm83_opcode_c0_df_executor.sv
`timescale 1ns / 1ps

// Executor for opcodes 0xC0..0xDF (returns, jumps, calls, restarts, push/pop
// of BC and DE, and 8-bit add/subtract with an immediate byte).
// req carries one instruction per transfer: cmd, imm_word (bytes after the
// opcode) and stack_word (word stored at SP). rsp carries one result per
// instruction: an optional stack write plus the full register state after it.
// Each request passes through the input register and then the result register.
// Throughput: one instruction per cycle while rsp does not stall. Register
// state is committed when an instruction moves from the input register to the
// result register, so the next instruction always sees the state left by the
// one before it.
// Reset clears A, F, BC, DE and PC, sets SP to 0xFFFE, and empties both
// pipeline registers.
// When rsp stalls, the result register holds, the input register holds behind
// it, and req.ready drops once both are full.
module sm83_opcode_c0_df_executor (
    input  logic         clk,
    input  logic         rst_n,
    sm83x_req_if.sink    req,
    sm83x_rsp_if.source  rsp
);
    import sm83x_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] imm_reg;
    logic [15:0] stack_reg;
    arch_t       state_reg;
    arch_t       state_next;
    wr_t         wr_next;
    logic        out_valid_reg;
    res_t        out_reg;
    logic        advance;
    logic        take;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    sm83x_exec u_exec (
        .cmd        (cmd_reg),
        .imm_word   (imm_reg),
        .stack_word (stack_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .wr         (wr_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg   <= req.cmd;
            imm_reg   <= req.imm_word;
            stack_reg <= req.stack_word;
        end
    end

    // commit architectural state with the transfer into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{acc: 8'd0, flags: 4'd0, bc: 16'd0, de: 16'd0,
                           sp: SP_RESET, pc: 16'd0};
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            out_reg <= '{wr: wr_next, st: state_next};
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.write_enable = out_reg.wr.en;
    assign rsp.write_addr   = out_reg.wr.addr;
    assign rsp.write_data   = out_reg.wr.data;
    assign rsp.next_pc      = out_reg.st.pc;
    assign rsp.next_sp      = out_reg.st.sp;
    assign rsp.acc_out      = out_reg.st.acc;
    assign rsp.flags_out    = out_reg.st.flags;
    assign rsp.pair_bc      = out_reg.st.bc;
    assign rsp.pair_de      = out_reg.st.de;

    a_wr_addr_is_sp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.wr.en |-> out_reg.wr.addr == out_reg.st.sp)
        else $error("stack write address differs from new SP");

    a_no_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.wr.en |-> out_reg.wr.addr == 16'd0 && out_reg.wr.data == 16'd0)
        else $error("idle write fields not zero");

    a_push_drops_sp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && wr_next.en |=> state_reg.sp == $past(state_reg.sp) - 16'd2)
        else $error("stack write without SP decrement");

    a_flags_only_alu: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && advance && cmd_reg[2:0] != GRP_ALU |=> $stable(state_reg.flags))
        else $error("flags changed by non-arithmetic opcode");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid_reg && advance) |=> $stable(state_reg))
        else $error("register state changed without commit");

endmodule
